[rtl/core/sobel_edge_magnitude_rgb_core_macros.svh]
// Assertion macros for the Sobel edge magnitude core checker.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_CORE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SEDM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sedm checker: property failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SEDM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sedm checker: property failed");

`endif

[rtl/core/sedm_pkg.sv]
// Shared types and constants of the Sobel edge magnitude core.
`default_nettype none
package sedm_pkg;
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_index_t;

    localparam int TAP_CNT    = 9;
    localparam int TAP_W      = 4;
    localparam int GRAD_W     = 11;
    localparam int SUM_W      = 22;
    localparam int ROOT_STEPS = 11;
    localparam int STEP_W     = 4;
    localparam int SH_W       = 5;
    localparam int SAT_MAX    = 255;

    typedef logic [TAP_W-1:0]  tap_t;
    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [1:0] {
        OFS_NEG  = 2'b00,
        OFS_ZERO = 2'b01,
        OFS_POS  = 2'b10
    } ofs_t;

    localparam logic signed [2:0] KERN_X [TAP_CNT] = '{
        -3'sd1, 3'sd0, 3'sd1, -3'sd2, 3'sd0, 3'sd2, -3'sd1, 3'sd0, 3'sd1};
    localparam logic signed [2:0] KERN_Y [TAP_CNT] = '{
        -3'sd1, -3'sd2, -3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd1, 3'sd2, 3'sd1};

    localparam ofs_t TAP_ROW [TAP_CNT] = '{
        OFS_NEG, OFS_NEG, OFS_NEG, OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_POS, OFS_POS, OFS_POS};
    localparam ofs_t TAP_COL [TAP_CNT] = '{
        OFS_NEG, OFS_ZERO, OFS_POS, OFS_NEG, OFS_ZERO, OFS_POS, OFS_NEG, OFS_ZERO, OFS_POS};

    typedef struct packed {
        logic  take;
        logic  rd;
        logic  acc;
        logic  sq;
        logic  rt;
        logic  load;
        tap_t  tap;
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic produce;
        logic out_free;
    } status_t;
endpackage
`default_nettype wire

[rtl/core/sedm_ifs.sv]
// Stream and configuration interfaces of the Sobel edge magnitude core.
`default_nettype none
interface sedm_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       flush;
    modport source (output valid, pixel_red, pixel_green, pixel_blue, flush, input ready);
    modport sink (input valid, pixel_red, pixel_green, pixel_blue, flush, output ready);
endinterface

interface sedm_edge_if;
    logic       valid;
    logic       ready;
    logic [7:0] edge_red;
    logic [7:0] edge_green;
    logic [7:0] edge_blue;
    logic       frame_last;
    modport source (output valid, edge_red, edge_green, edge_blue, frame_last, input ready);
    modport sink (input valid, edge_red, edge_green, edge_blue, frame_last, output ready);
endinterface

interface sedm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/sedm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sedm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2051
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

[rtl/core/sedm_ctrl.sv]
// Controller state machine: sequences tap reads, accumulate, squares, root steps, output load.
`default_nettype none
module sedm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sedm_pkg::status_t status,
    output sedm_pkg::cmd_t         cmd
);
    import sedm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_ACC  = 6'b000100,
        S_SQR  = 6'b001000,
        S_ROOT = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    tap_t   tap_reg, tap_next;
    step_t  step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.tap    = tap_reg;
        cmd.step   = step_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                if (in_valid && status.produce)
                begin
                    tap_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd  = 1'b1;
                cmd.acc = (tap_reg != '0);
                if (tap_reg == TAP_W'(TAP_CNT - 1))
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    tap_next = tap_reg + TAP_W'(1);
                end
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_SQR;
            end
            S_SQR:
            begin
                cmd.sq     = 1'b1;
                step_next  = '0;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.rt = 1'b1;
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tap_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            step_reg  <= step_next;
        end
    end
endmodule
`default_nettype wire

[rtl/core/sedm_datapath.sv]
// Datapath: frame counters, pixel ring, gradient accumulators, root unit, output word.
`default_nettype none
module sedm_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire sedm_pkg::cmd_t                     cmd,
    output sedm_pkg::status_t                       status,
    input  wire logic [sedm_pkg::PIX_W-1:0]         pixel_red,
    input  wire logic [sedm_pkg::PIX_W-1:0]         pixel_green,
    input  wire logic [sedm_pkg::PIX_W-1:0]         pixel_blue,
    input  wire logic                               flush,
    input  wire logic                               cfg_we,
    input  wire logic [sedm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sedm_pkg::CFG_W-1:0]         cfg_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [sedm_pkg::PIX_W-1:0]              edge_red,
    output logic [sedm_pkg::PIX_W-1:0]              edge_green,
    output logic [sedm_pkg::PIX_W-1:0]              edge_blue,
    output logic                                    frame_last
);
    import sedm_pkg::*;

    localparam int XW   = $clog2(MAX_WIDTH + 2);
    localparam int YW   = $clog2(MAX_HEIGHT + 2);
    localparam int RING = 2 * MAX_WIDTH + 3;
    localparam int AW   = $clog2(RING);
    localparam int PXW  = 3 * PIX_W;

    logic [CFG_W-1:0] width_cfg_reg, height_cfg_reg;
    logic [XW-1:0]    w_eff;
    logic [YW-1:0]    h_eff;

    logic [XW-1:0] in_col_reg, out_col_reg, lag_reg;
    logic [YW-1:0] in_row_reg, out_row_reg;
    logic [AW-1:0] ring_pos_reg, ring_next;

    logic counted, lag_full, last;

    logic [AW-1:0]  rd_addr;
    logic [AW:0]    rowback, back_dist, addr_raw;
    logic           row_ok, col_ok;
    logic [PXW-1:0] rd_data;
    tap_t           tap_d_reg;
    logic           tap_ok_reg;

    logic signed [GRAD_W-1:0] gx_reg [3];
    logic signed [GRAD_W-1:0] gy_reg [3];
    logic [SUM_W-1:0]         rem_reg [3];
    logic [SUM_W-1:0]         root_reg [3];
    logic [PIX_W-1:0]         sat [3];
    logic [SH_W-1:0]          sh;
    logic [SUM_W-1:0]         bitv;

    logic out_valid_reg;

    always_comb
    begin
        if (width_cfg_reg == '0)
            w_eff = XW'(1);
        else if (32'(width_cfg_reg) > 32'(MAX_WIDTH))
            w_eff = XW'(MAX_WIDTH);
        else
            w_eff = XW'(width_cfg_reg);
        if (height_cfg_reg == '0)
            h_eff = YW'(1);
        else if (32'(height_cfg_reg) > 32'(MAX_HEIGHT))
            h_eff = YW'(MAX_HEIGHT);
        else
            h_eff = YW'(height_cfg_reg);
    end

    assign counted   = flush ? (in_row_reg >= h_eff) : (in_row_reg < h_eff);
    assign lag_full  = (lag_reg == w_eff + XW'(1));
    assign ring_next = (ring_pos_reg == AW'(RING - 1)) ? '0 : ring_pos_reg + AW'(1);
    assign last      = (out_row_reg == h_eff - YW'(1)) && (out_col_reg == w_eff - XW'(1));

    assign status.produce  = counted && lag_full;
    assign status.out_free = !out_valid_reg || out_ready;

    // Ring distance of a tap from the newest stored pixel, its read address and whether it lies in the frame.
    always_comb
    begin
        case (TAP_ROW[cmd.tap])
            OFS_NEG:  rowback = (AW + 1)'(w_eff) << 1;
            OFS_ZERO: rowback = (AW + 1)'(w_eff);
            default:  rowback = '0;
        endcase
        case (TAP_COL[cmd.tap])
            OFS_NEG:  back_dist = rowback + (AW + 1)'(2);
            OFS_ZERO: back_dist = rowback + (AW + 1)'(1);
            default:  back_dist = rowback;
        endcase
        addr_raw = (AW + 1)'(ring_pos_reg) + (AW + 1)'(RING) - back_dist;
        if (addr_raw >= (AW + 1)'(RING))
            rd_addr = AW'(addr_raw - (AW + 1)'(RING));
        else
            rd_addr = AW'(addr_raw);
        case (TAP_ROW[cmd.tap])
            OFS_NEG:  row_ok = (out_row_reg != '0);
            OFS_ZERO: row_ok = 1'b1;
            default:  row_ok = (out_row_reg + YW'(1)) < h_eff;
        endcase
        case (TAP_COL[cmd.tap])
            OFS_NEG:  col_ok = (out_col_reg != '0);
            OFS_ZERO: col_ok = 1'b1;
            default:  col_ok = (out_col_reg + XW'(1)) < w_eff;
        endcase
    end

    sedm_ram #(
        .WIDTH (PXW),
        .DEPTH (RING)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (cmd.take && counted && !flush),
        .wr_addr (ring_next),
        .wr_data ({pixel_red, pixel_green, pixel_blue}),
        .rd_en   (cmd.rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= CFG_DIM_RESET;
            height_cfg_reg <= CFG_DIM_RESET;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            lag_reg        <= '0;
            ring_pos_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_FRAME_WIDTH:
                    begin
                        width_cfg_reg <= cfg_data;
                        in_col_reg    <= '0;
                        in_row_reg    <= '0;
                        out_col_reg   <= '0;
                        out_row_reg   <= '0;
                        lag_reg       <= '0;
                    end
                    CFG_FRAME_HEIGHT:
                    begin
                        height_cfg_reg <= cfg_data;
                        in_col_reg     <= '0;
                        in_row_reg     <= '0;
                        out_col_reg    <= '0;
                        out_row_reg    <= '0;
                        lag_reg        <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd.take && counted)
            begin
                ring_pos_reg <= ring_next;
                if (!lag_full)
                    lag_reg <= lag_reg + XW'(1);
                if (in_col_reg + XW'(1) >= w_eff)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + YW'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + XW'(1);
                end
            end
            else if (cmd.load)
            begin
                if (last)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                    lag_reg     <= '0;
                end
                else if (out_col_reg + XW'(1) >= w_eff)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + YW'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + XW'(1);
                end
            end

            if (cmd.load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Root step: bit weight 4^(ROOT_STEPS-1-step).
    assign sh   = SH_W'(2 * (ROOT_STEPS - 1)) - SH_W'({cmd.step, 1'b0});
    assign bitv = SUM_W'(1) << sh;

    always_comb
    begin
        logic [SUM_W-1:0] r;
        for (int ch = 0; ch < 3; ch++)
        begin
            r = (rem_reg[ch] > root_reg[ch]) ? root_reg[ch] + SUM_W'(1) : root_reg[ch];
            sat[ch] = (r > SUM_W'(SAT_MAX)) ? PIX_W'(SAT_MAX) : PIX_W'(r);
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [GRAD_W-1:0] v;
        logic signed [GRAD_W-1:0] kx;
        logic signed [GRAD_W-1:0] ky;
        logic signed [SUM_W-1:0]  gxw;
        logic signed [SUM_W-1:0]  gyw;
        logic [SUM_W-1:0]         trial;
        if (cmd.rd)
        begin
            tap_d_reg  <= cmd.tap;
            tap_ok_reg <= row_ok && col_ok;
        end
        kx = GRAD_W'(KERN_X[tap_d_reg]);
        ky = GRAD_W'(KERN_Y[tap_d_reg]);
        for (int ch = 0; ch < 3; ch++)
        begin
            v     = signed'({{(GRAD_W - PIX_W){1'b0}}, rd_data[PXW-1-PIX_W*ch -: PIX_W]});
            gxw   = SUM_W'(gx_reg[ch]);
            gyw   = SUM_W'(gy_reg[ch]);
            trial = root_reg[ch] + bitv;
            if (cmd.take)
            begin
                gx_reg[ch] <= '0;
                gy_reg[ch] <= '0;
            end
            else if (cmd.acc && tap_ok_reg)
            begin
                gx_reg[ch] <= gx_reg[ch] + GRAD_W'(v * kx);
                gy_reg[ch] <= gy_reg[ch] + GRAD_W'(v * ky);
            end
            if (cmd.sq)
            begin
                rem_reg[ch]  <= SUM_W'(gxw * gxw) + SUM_W'(gyw * gyw);
                root_reg[ch] <= '0;
            end
            else if (cmd.rt)
            begin
                if (rem_reg[ch] >= trial)
                begin
                    rem_reg[ch]  <= rem_reg[ch] - trial;
                    root_reg[ch] <= (root_reg[ch] >> 1) + bitv;
                end
                else
                begin
                    root_reg[ch] <= root_reg[ch] >> 1;
                end
            end
        end
        if (cmd.load)
        begin
            edge_red   <= sat[0];
            edge_green <= sat[1];
            edge_blue  <= sat[2];
            frame_last <= last;
        end
    end

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

[rtl/core/sobel_edge_magnitude_rgb_core.sv]
// Top level of the Sobel edge magnitude core for RGB pixel streams.
//
// pixel_in takes one pixel word per handshake in raster order; flush words
// (flush = 1) carry no pixel and drain the last row after frame end, and
// frame_width + 1 of them finish a frame. Words that do not fit the frame
// position are taken and dropped. edge_out gives one word per pixel, the
// result for the pixel one row plus one pixel behind the input, with
// frame_last set on the frame's final pixel. cfg writes frame_width (index 0)
// or frame_height (index 1), is always ready and restarts the frame.
// A word that yields no result is taken and leaves pixel_in ready. After a
// word that yields a result, pixel_in is not ready while the block runs 9
// line-store reads on the single read port, an accumulate, a square, 11 root
// steps and the output load, and the result is valid from the cycle after
// the load. The output register lets the next word be taken while a result
// waits; a stalled receiver holds the block in the load step only once a
// second result is ready.
// Reset clears the counters, sets both dimensions to 1024 and empties the
// output; the line store is not cleared.
`default_nettype none
module sobel_edge_magnitude_rgb_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input wire logic     clk,
    input wire logic     rst_n,
    sedm_pixel_if.sink   pixel_in,
    sedm_edge_if.source  edge_out,
    sedm_cfg_if.sink     cfg
);
    import sedm_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg.ready = 1'b1;

    sedm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel_in.valid),
        .in_ready (pixel_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    sedm_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .pixel_red   (pixel_in.pixel_red),
        .pixel_green (pixel_in.pixel_green),
        .pixel_blue  (pixel_in.pixel_blue),
        .flush       (pixel_in.flush),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .out_valid   (edge_out.valid),
        .out_ready   (edge_out.ready),
        .edge_red    (edge_out.edge_red),
        .edge_green  (edge_out.edge_green),
        .edge_blue   (edge_out.edge_blue),
        .frame_last  (edge_out.frame_last)
    );
endmodule
`default_nettype wire

[rtl/core/sedm_checker.sv]
// Port-level checker for the Sobel edge magnitude core, with its bind.
`default_nettype none
`include "sobel_edge_magnitude_rgb_core_macros.svh"
module sedm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] edge_red,
    input wire logic [7:0] edge_green,
    input wire logic [7:0] edge_blue,
    input wire logic       frame_last
);
    `SEDM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `SEDM_ASSERT_NEXT(a_word_hold, out_valid && !out_ready, $stable({edge_red, edge_green, edge_blue, frame_last}))
    `SEDM_ASSERT_IMPL(a_load_busy, $rose(out_valid), !$past(in_ready))
endmodule

bind sobel_edge_magnitude_rgb_core sedm_checker u_sedm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (pixel_in.ready),
    .out_valid  (edge_out.valid),
    .out_ready  (edge_out.ready),
    .edge_red   (edge_out.edge_red),
    .edge_green (edge_out.edge_green),
    .edge_blue  (edge_out.edge_blue),
    .frame_last (edge_out.frame_last)
);
`default_nettype wire
